### hw/rtl/mos6502_eu_pkg.sv
package mos6502_eu_pkg;
  localparam logic [5:0] OP_NOP = 6'd0, OP_ADC = 6'd1, OP_SBC = 6'd2, OP_AND = 6'd3,
    OP_ORA = 6'd4, OP_EOR = 6'd5, OP_CMP = 6'd6, OP_CPX = 6'd7, OP_CPY = 6'd8,
    OP_BIT = 6'd9, OP_LDA = 6'd10, OP_LDX = 6'd11, OP_LDY = 6'd12, OP_LAX = 6'd13,
    OP_TAX = 6'd14, OP_TAY = 6'd15, OP_TXA = 6'd16, OP_TYA = 6'd17, OP_TSX = 6'd18,
    OP_TXS = 6'd19, OP_INX = 6'd20, OP_INY = 6'd21, OP_DEX = 6'd22, OP_DEY = 6'd23,
    OP_ASL_A = 6'd24, OP_LSR_A = 6'd25, OP_ROL_A = 6'd26, OP_ROR_A = 6'd27,
    OP_ASL_M = 6'd28, OP_LSR_M = 6'd29, OP_ROL_M = 6'd30, OP_ROR_M = 6'd31,
    OP_INC_M = 6'd32, OP_DEC_M = 6'd33, OP_CLC = 6'd34, OP_SEC = 6'd35,
    OP_CLI = 6'd36, OP_SEI = 6'd37, OP_CLD = 6'd38, OP_SED = 6'd39, OP_CLV = 6'd40,
    OP_BPL = 6'd41, OP_BMI = 6'd42, OP_BVC = 6'd43, OP_BVS = 6'd44, OP_BCC = 6'd45,
    OP_BCS = 6'd46, OP_BNE = 6'd47, OP_BEQ = 6'd48, OP_JMP = 6'd49, OP_ANC = 6'd50,
    OP_ARR = 6'd51, OP_AXS = 6'd52, OP_ALR = 6'd53, OP_LXA = 6'd54, OP_ANE = 6'd55,
    OP_SLO = 6'd56, OP_SRE = 6'd57, OP_RLA = 6'd58, OP_RRA = 6'd59, OP_DCP = 6'd60,
    OP_ISC = 6'd61;
  localparam int FL_C = 0, FL_Z = 1, FL_I = 2, FL_D = 3, FL_V = 6, FL_N = 7;
endpackage

### hw/rtl/mos6502_execute_unit_core.sv
// The result beat is registered and appears in the cycle after the input beat is accepted.
// Throughput: one operation per cycle while results are taken every cycle; the
// register file feedback through the 8-bit adder and flag logic is combinational.
// The architectural registers double as the result register, so a result beat
// that waits stalls the input until it is taken.
// Reset (rst_ni low, asynchronous) clears A, X, Y, SP, P and PC to zero.
module mos6502_execute_unit_core import mos6502_eu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  mode_i,
  input  logic [7:0]  operand_value_i,
  input  logic [15:0] target_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  accumulator_out_o,
  output logic [7:0]  index_x_out_o,
  output logic [7:0]  index_y_out_o,
  output logic [7:0]  stack_pointer_out_o,
  output logic [7:0]  status_out_o,
  output logic [15:0] program_counter_out_o,
  output logic [7:0]  write_value_o,
  output logic        write_enable_o,
  output logic [1:0]  extra_cycles_o
);
  logic [7:0] a_q, x_q, y_q, sp_q, p_q;
  logic [15:0] pc_q;
  logic [7:0] a_d, x_d, y_d, sp_d, p_d;
  logic [15:0] pc_d;
  logic [7:0] wv_d, wv_q;
  logic we_d, we_q;
  logic [1:0] ex_d, ex_q;
  logic ov_q;

  logic [7:0] add_m, sum8, cmp_r, cmp_m, sh_in, sh_out;
  logic [8:0] sum9, diff9;
  logic add_en, cmp_en, sh_left, sh_cin, sh_en;
  logic [15:0] br_pc;
  logic c, add_cin;

  assign in_ready_o = !ov_q || out_ready_i;
  assign c = p_q[FL_C];
  // RRA adds with the carry that its rotate shifted out
  assign add_cin = (mode_i == OP_RRA) ? operand_value_i[0] : c;

  always_comb begin
    add_en = 1'b0; add_m = operand_value_i;
    cmp_en = 1'b0; cmp_r = a_q; cmp_m = operand_value_i;
    sh_en = 1'b0; sh_left = 1'b0; sh_cin = 1'b0; sh_in = operand_value_i;
    unique case (mode_i)
      OP_ADC: add_en = 1'b1;
      OP_SBC: begin add_en = 1'b1; add_m = ~operand_value_i; end
      OP_CMP: cmp_en = 1'b1;
      OP_CPX: begin cmp_en = 1'b1; cmp_r = x_q; end
      OP_CPY: begin cmp_en = 1'b1; cmp_r = y_q; end
      OP_ASL_A: begin sh_en = 1'b1; sh_left = 1'b1; sh_in = a_q; end
      OP_LSR_A: begin sh_en = 1'b1; sh_in = a_q; end
      OP_ROL_A: begin sh_en = 1'b1; sh_left = 1'b1; sh_cin = c; sh_in = a_q; end
      OP_ROR_A: begin sh_en = 1'b1; sh_cin = c; sh_in = a_q; end
      OP_ASL_M, OP_SLO: begin sh_en = 1'b1; sh_left = 1'b1; end
      OP_LSR_M, OP_SRE: sh_en = 1'b1;
      OP_ROL_M, OP_RLA: begin sh_en = 1'b1; sh_left = 1'b1; sh_cin = c; end
      OP_ROR_M, OP_RRA: begin sh_en = 1'b1; sh_cin = c; end
      OP_ALR: begin sh_en = 1'b1; sh_in = a_q & operand_value_i; end
      OP_DCP: begin cmp_en = 1'b1; cmp_m = operand_value_i - 8'd1; end
      OP_ISC: begin add_en = 1'b1; add_m = ~(operand_value_i + 8'd1); end
      OP_AXS: begin cmp_r = a_q & x_q; end
      default: ;
    endcase
  end

  // shared datapath: one 8-bit ALU adder, one comparator, one shifter (inc/dec and branch target have their own adders)
  assign sum9  = {1'b0, a_q} + {1'b0, (mode_i == OP_RRA) ? sh_out : add_m} + {8'd0, add_cin};
  assign sum8  = sum9[7:0];
  assign diff9 = {1'b0, cmp_r} - {1'b0, cmp_m};
  assign sh_out = sh_left ? {sh_in[6:0], sh_cin} : {sh_cin, sh_in[7:1]};
  assign br_pc = pc_q + {{8{operand_value_i[7]}}, operand_value_i};

  always_comb begin
    logic [7:0] am, addm_eff, r;
    logic [7:0] a_n, x_n, y_n, sp_n, p_n, wv_n;
    logic [15:0] pc_n;
    logic we_n, tk;
    logic [1:0] ex_n;
    am = a_q & operand_value_i;
    addm_eff = (mode_i == OP_RRA) ? sh_out : add_m;
    r = {c, am[7:1]};
    a_n = a_q; x_n = x_q; y_n = y_q; sp_n = sp_q; p_n = p_q; pc_n = pc_q;
    wv_n = 8'h00; we_n = 1'b0; ex_n = 2'd0; tk = 1'b0;
    if (sh_en) p_n[FL_C] = sh_left ? sh_in[7] : sh_in[0];
    if (cmp_en) begin
      p_n[FL_C] = !diff9[8]; p_n[FL_Z] = (diff9[7:0] == 8'h00); p_n[FL_N] = diff9[7];
    end
    if (add_en || mode_i == OP_RRA) begin
      p_n[FL_C] = sum9[8];
      p_n[FL_V] = (~(a_q[7] ^ addm_eff[7])) & (a_q[7] ^ sum8[7]);
    end
    unique case (mode_i)
      OP_ADC, OP_SBC, OP_ISC, OP_RRA: a_n = sum8;
      OP_AND, OP_ANC: a_n = am;
      OP_ORA: a_n = a_q | operand_value_i;
      OP_EOR: a_n = a_q ^ operand_value_i;
      OP_BIT: begin
        p_n[FL_Z] = (am == 8'h00); p_n[FL_V] = operand_value_i[6];
        p_n[FL_N] = operand_value_i[7];
      end
      OP_LDA: a_n = operand_value_i;
      OP_LDX: x_n = operand_value_i;
      OP_LDY: y_n = operand_value_i;
      OP_LAX: begin a_n = operand_value_i; x_n = operand_value_i; end
      OP_TAX: x_n = a_q;
      OP_TAY: y_n = a_q;
      OP_TXA: a_n = x_q;
      OP_TYA: a_n = y_q;
      OP_TSX: x_n = sp_q;
      OP_TXS: sp_n = x_q;
      OP_INX: x_n = x_q + 8'd1;
      OP_INY: y_n = y_q + 8'd1;
      OP_DEX: x_n = x_q - 8'd1;
      OP_DEY: y_n = y_q - 8'd1;
      OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A, OP_ALR: a_n = sh_out;
      OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin wv_n = sh_out; we_n = 1'b1; end
      OP_INC_M: begin wv_n = operand_value_i + 8'd1; we_n = 1'b1; end
      OP_DEC_M: begin wv_n = operand_value_i - 8'd1; we_n = 1'b1; end
      OP_CLC: p_n[FL_C] = 1'b0;
      OP_SEC: p_n[FL_C] = 1'b1;
      OP_CLI: p_n[FL_I] = 1'b0;
      OP_SEI: p_n[FL_I] = 1'b1;
      OP_CLD: p_n[FL_D] = 1'b0;
      OP_SED: p_n[FL_D] = 1'b1;
      OP_CLV: p_n[FL_V] = 1'b0;
      OP_BPL: tk = !p_q[FL_N];
      OP_BMI: tk = p_q[FL_N];
      OP_BVC: tk = !p_q[FL_V];
      OP_BVS: tk = p_q[FL_V];
      OP_BCC: tk = !p_q[FL_C];
      OP_BCS: tk = p_q[FL_C];
      OP_BNE: tk = !p_q[FL_Z];
      OP_BEQ: tk = p_q[FL_Z];
      OP_JMP: pc_n = target_address_i;
      OP_ARR: a_n = r;
      OP_AXS: x_n = diff9[7:0];
      OP_LXA: begin a_n = am; x_n = am; end
      OP_ANE: a_n = am & x_q;
      OP_SLO: begin wv_n = sh_out; we_n = 1'b1; a_n = a_q | sh_out; end
      OP_SRE: begin wv_n = sh_out; we_n = 1'b1; a_n = a_q ^ sh_out; end
      OP_RLA: begin wv_n = sh_out; we_n = 1'b1; a_n = a_q & sh_out; end
      OP_DCP: begin wv_n = cmp_m; we_n = 1'b1; end
      default: ;
    endcase
    if (mode_i == OP_ISC) begin wv_n = operand_value_i + 8'd1; we_n = 1'b1; end
    if (mode_i == OP_RRA) begin wv_n = sh_out; we_n = 1'b1; end
    // set N/Z from whichever register or memory write value the op produced
    priority case (mode_i)
      OP_LDX, OP_LAX, OP_TAX, OP_TSX, OP_INX, OP_DEX, OP_AXS, OP_LXA: begin
        p_n[FL_Z] = (x_n == 8'h00); p_n[FL_N] = x_n[7];
      end
      OP_LDY, OP_TAY, OP_INY, OP_DEY: begin
        p_n[FL_Z] = (y_n == 8'h00); p_n[FL_N] = y_n[7];
      end
      OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M, OP_INC_M, OP_DEC_M: begin
        p_n[FL_Z] = (wv_n == 8'h00); p_n[FL_N] = wv_n[7];
      end
      OP_ADC, OP_SBC, OP_ISC, OP_RRA, OP_AND, OP_ORA, OP_EOR, OP_LDA, OP_TXA, OP_TYA,
      OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A, OP_ALR, OP_ANC, OP_ARR, OP_ANE,
      OP_SLO, OP_SRE, OP_RLA: begin
        p_n[FL_Z] = (a_n == 8'h00); p_n[FL_N] = a_n[7];
      end
      default: ;
    endcase
    if (mode_i == OP_ANC) p_n[FL_C] = am[7];
    if (mode_i == OP_ARR) begin p_n[FL_C] = r[6]; p_n[FL_V] = r[6] ^ r[5]; end
    if (mode_i == OP_AXS) p_n[FL_C] = !diff9[8];
    if (tk) begin
      pc_n = br_pc;
      ex_n = (br_pc[15:8] != pc_q[15:8]) ? 2'd2 : 2'd1;
    end
    a_d = a_n; x_d = x_n; y_d = y_n; sp_d = sp_n; p_d = p_n; pc_d = pc_n;
    wv_d = wv_n; we_d = we_n; ex_d = ex_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 8'h00; x_q <= 8'h00; y_q <= 8'h00; sp_q <= 8'h00; p_q <= 8'h00;
      pc_q <= 16'h0000; ov_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d; pc_q <= pc_d;
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      wv_q <= wv_d; we_q <= we_d; ex_q <= ex_d;
    end
  end

  assign out_valid_o = ov_q;
  assign accumulator_out_o = a_q;
  assign index_x_out_o = x_q;
  assign index_y_out_o = y_q;
  assign stack_pointer_out_o = sp_q;
  assign status_out_o = p_q;
  assign program_counter_out_o = pc_q;
  assign write_value_o = wv_q;
  assign write_enable_o = we_q;
  assign extra_cycles_o = ex_q;
endmodule
